// ===== rtl/aus_pkg.sv =====
// shared types and constants for the access unit splitter
// no dependencies
`timescale 1ns / 1ps

package aus_pkg;

  localparam int WINDOW_BYTES = 8;
  localparam int IDX_W        = $clog2(WINDOW_BYTES);
  localparam int FILL_W       = $clog2(WINDOW_BYTES + 1);

  localparam logic [4:0] TYPE_MASK     = 5'h1f;
  localparam logic [IDX_W-1:0] SKIP_LEN = IDX_W'(WINDOW_BYTES - 1);

  localparam logic [4:0] NAL_SLICE     = 5'd1;
  localparam logic [4:0] NAL_IDR       = 5'd5;
  localparam logic [4:0] NAL_SEI       = 5'd6;
  localparam logic [4:0] NAL_SPS       = 5'd7;
  localparam logic [4:0] NAL_PPS       = 5'd8;
  localparam logic [4:0] NAL_RSVD15    = 5'd15;
  localparam logic [4:0] NAL_SLICE_EXT = 5'd20;

  typedef logic [WINDOW_BYTES-1:0][7:0] window_t;

  typedef struct packed {
    logic [7:0] byte_out;
    logic       window_full;
    logic       unit_begins;
    logic       first_slice_found;
  } result_t;

endpackage

// ===== rtl/aus_cell.sv =====
// one byte stage of the stream window, shifts toward the oldest end
// depends on nothing
`timescale 1ns / 1ps

module aus_cell (
  input  logic       clk,
  input  logic       shift,
  input  logic [7:0] d,
  output logic [7:0] q
);

  logic [7:0] stored;

  always_ff @(posedge clk) begin
    if (shift) begin
      stored <= d;
    end
  end

  assign q = stored;

endmodule

// ===== rtl/aus_ctrl.sv =====
// start code detection, phase, skip and fill tracking for one window step
// depends on aus_pkg
`timescale 1ns / 1ps

module aus_ctrl import aus_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    step,
  input  window_t win,
  output result_t res
);

  logic              end_phase;
  logic [IDX_W-1:0]  skip_count;
  logic [FILL_W-1:0] fill_count;

  logic              end_phase_next;
  logic [IDX_W-1:0]  skip_count_next;
  logic [FILL_W-1:0] fill_count_next;

  logic       start_code;
  logic [4:0] nal_type;
  logic       first_slice;
  logic       other_boundary;
  logic       full;
  logic       begins;
  logic       found;
  logic       phase_mid;

  assign start_code = (win[0] == 8'h00) && (win[1] == 8'h00) && (win[2] == 8'h01);
  assign nal_type   = win[3][4:0] & TYPE_MASK;

  assign first_slice = start_code &&
    ((((nal_type == NAL_SLICE) || (nal_type == NAL_IDR)) && win[4][7]) ||
     ((nal_type == NAL_SLICE_EXT) && win[WINDOW_BYTES-1][7]));

  assign other_boundary = start_code &&
    ((nal_type == NAL_SEI) || (nal_type == NAL_SPS) ||
     (nal_type == NAL_PPS) || (nal_type == NAL_RSVD15));

  assign full = fill_count >= FILL_W'(WINDOW_BYTES - 1);

  always_comb begin
    begins          = 1'b0;
    found           = 1'b0;
    phase_mid       = end_phase;
    end_phase_next  = end_phase;
    skip_count_next = skip_count;
    fill_count_next = (fill_count < FILL_W'(WINDOW_BYTES)) ?
                      fill_count + FILL_W'(1) : fill_count;
    if (full) begin
      if (skip_count != '0) begin
        skip_count_next = skip_count - IDX_W'(1);
      end else begin
        begins    = end_phase && (first_slice || other_boundary);
        phase_mid = begins ? 1'b0 : end_phase;
        if (!phase_mid && first_slice) begin
          found           = 1'b1;
          end_phase_next  = 1'b1;
          skip_count_next = SKIP_LEN;
        end else begin
          end_phase_next = phase_mid;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      end_phase  <= 1'b0;
      skip_count <= '0;
      fill_count <= '0;
    end else if (step) begin
      end_phase  <= end_phase_next;
      skip_count <= skip_count_next;
      fill_count <= fill_count_next;
    end
  end

  assign res.byte_out          = full ? win[0] : 8'h00;
  assign res.window_full       = full;
  assign res.unit_begins       = begins;
  assign res.first_slice_found = found;

  // skipping only happens after a first slice
  a_skip_in_end_phase: assert property (@(posedge clk) disable iff (rst)
    (skip_count != '0) |-> end_phase)
    else $error("skip count running outside end phase");

  a_found_arms_skip: assert property (@(posedge clk) disable iff (rst)
    (step && res.first_slice_found) |=> (end_phase && skip_count == SKIP_LEN))
    else $error("first slice did not arm the skip");

  a_begins_needs_end_phase: assert property (@(posedge clk) disable iff (rst)
    (step && res.unit_begins) |-> (end_phase && skip_count == '0 && full))
    else $error("unit boundary outside end phase");

  a_fill_bounded: assert property (@(posedge clk) disable iff (rst)
    fill_count <= FILL_W'(WINDOW_BYTES))
    else $error("fill count overran window size");

endmodule

// ===== rtl/aus_obuf.sv =====
// two-entry result buffer between the window step and the output channel
// depends on aus_pkg
`timescale 1ns / 1ps

module aus_obuf import aus_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  output logic    has_room,
  output logic    head_valid,
  input  logic    pop_ready,
  output result_t head_data
);

  result_t head;
  result_t tail;
  logic    head_full;
  logic    tail_full;
  logic    pop;

  assign has_room   = !tail_full;
  assign head_valid = head_full;
  assign head_data  = head;
  assign pop        = head_full && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_full <= 1'b0;
      tail_full <= 1'b0;
    end else begin
      if (pop) begin
        if (tail_full) begin
          tail_full <= 1'b0;
        end else if (!push) begin
          head_full <= 1'b0;
        end
      end else if (push) begin
        if (!head_full) begin
          head_full <= 1'b1;
        end else begin
          tail_full <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (tail_full) begin
        head <= tail;
      end else if (push) begin
        head <= push_data;
      end
    end else if (push) begin
      if (!head_full) begin
        head <= push_data;
      end else begin
        tail <= push_data;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    tail_full |-> head_full)
    else $error("tail entry held without head entry");

endmodule

// ===== rtl/h264_access_unit_splitter_top.sv =====
// top level of the annex b access unit splitter
// depends on aus_pkg, aus_cell, aus_ctrl, aus_obuf
//
//   channel | signals                                     | dir
//   --------+---------------------------------------------+----
//   in      | in_valid, in_ready, data_byte               | in
//   out     | out_valid, out_ready, byte_out, window_full,| out
//           | unit_begins, first_slice_found              |
//
// one byte per cycle while in_ready is high; each transfer in yields one result transfer out
// result for a byte is registered into the result buffer with its transfer
// byte_out lags the input stream by seven bytes through the eight-cell window
// a two-entry result buffer absorbs a result while the output stalls; in_ready drops when both are held
// rst clears phase, skip and fill state and empties the result buffer; the window contents need no reset
`timescale 1ns / 1ps

module h264_access_unit_splitter_top import aus_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] byte_out,
  output logic       window_full,
  output logic       unit_begins,
  output logic       first_slice_found
);

  logic    step;
  window_t cur;
  window_t win_next;
  result_t res;
  result_t head;

  assign step = in_valid && in_ready;

  // next window contents: each cell takes its younger neighbor
  always_comb begin
    for (int i = 0; i < WINDOW_BYTES - 1; i++) begin
      win_next[i] = cur[i+1];
    end
    win_next[WINDOW_BYTES-1] = data_byte;
  end

  for (genvar g = 0; g < WINDOW_BYTES; g++) begin : g_cell
    aus_cell u_cell (
      .clk   (clk),
      .shift (step),
      .d     (win_next[g]),
      .q     (cur[g])
    );
  end

  aus_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .win  (win_next),
    .res  (res)
  );

  aus_obuf u_obuf (
    .clk        (clk),
    .rst        (rst),
    .push       (step),
    .push_data  (res),
    .has_room   (in_ready),
    .head_valid (out_valid),
    .pop_ready  (out_ready),
    .head_data  (head)
  );

  assign byte_out          = head.byte_out;
  assign window_full       = head.window_full;
  assign unit_begins       = head.unit_begins;
  assign first_slice_found = head.first_slice_found;

endmodule
